@@ hdl/ifte_pkg.sv @@
package ifte_pkg;

   localparam int DIMS_W     = 10;
   localparam int THR_W      = 16;
   localparam int VAL_W      = 16;
   localparam int WS_W       = 18;
   localparam int SPLIT_W    = 17;
   localparam int STORE_W    = 32;
   localparam int PROD_W     = 34;
   localparam int ACC_W      = 35;
   localparam int TOK_W      = 16;
   localparam int ELEM_W     = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [SPLIT_W-1:0]   ONE_Q16      = 17'h10000;
   localparam logic [DIMS_W-1:0]    DIMS_RESET   = 10'd512;
   localparam logic [THR_W-1:0]     THR_RESET    = 16'd32768;
   localparam logic [CSR_IDX_W-1:0] REG_DIMS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAIL_THR = 2'd1;
   localparam logic                 FUNC_FRAME   = 1'b0;
   localparam logic                 FUNC_DRAIN   = 1'b1;

   typedef enum logic [2:0] {
      OP_ACC   = 3'b001,
      OP_FIRE  = 3'b010,
      OP_DRAIN = 3'b100
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } clr_state_type;

   typedef struct packed {
      op_type                    op;
      logic                      emit;
      logic [ELEM_W-1:0]         elem_idx;
      logic [TOK_W-1:0]          tok;
      logic                      last;
      logic                      tail;
      logic [SPLIT_W-1:0]        split;
      logic [SPLIT_W-1:0]        ws;
      logic signed [VAL_W-1:0]   value;
   } item_type;

   typedef struct packed {
      logic signed [STORE_W-1:0] embed;
      logic [ELEM_W-1:0]         elem_idx;
      logic [TOK_W-1:0]          tok;
      logic                      last;
      logic                      tail;
   } result_type;

   function automatic logic signed [STORE_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [STORE_W-1:0] r;
      if ((x[ACC_W-1:STORE_W-1] == '0) || (x[ACC_W-1:STORE_W-1] == '1)) begin
         r = x[STORE_W-1:0];
      end else if (x[ACC_W-1]) begin
         r = {1'b1, {(STORE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(STORE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

@@ hdl/ifte_ctrl.sv @@
module ifte_ctrl #(
   parameter int MAX_DIMS = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr,
   input  logic [ifte_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ifte_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                          accept,
   input  logic                          func,
   input  logic [15:0]                   alpha,
   input  logic signed [15:0]            enc_value,
   output logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] addr,
   output ifte_pkg::item_type            item
);
   import ifte_pkg::*;

   localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DIM_W = $clog2(MAX_DIMS + 1);
   localparam int CMP_W = (DIM_W > DIMS_W) ? DIM_W : DIMS_W;
   localparam logic [CMP_W-1:0] MAX_DIMS_C = CMP_W'(MAX_DIMS);

   logic [DIMS_W-1:0]  dims_ff, dims_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [WS_W-1:0]    ws_ff, ws_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               fires_ff, fires_in;
   logic [SPLIT_W-1:0] split_ff, split_in;
   logic [TOK_W-1:0]   tok_ff, tok_in;
   logic               tail_ff, tail_in;

   logic [CMP_W-1:0]   dims_eff;
   logic [CMP_W:0]     pos_next;
   logic               last;
   logic [WS_W:0]      sum_w;
   logic               fires_cur;
   logic               tail_cur;
   logic [SPLIT_W-1:0] split_cur;
   logic [WS_W-1:0]    ws_cur;

   always_comb begin
      if (dims_ff == '0) begin
         dims_eff = CMP_W'(1);
      end else if (CMP_W'(dims_ff) > MAX_DIMS_C) begin
         dims_eff = MAX_DIMS_C;
      end else begin
         dims_eff = CMP_W'(dims_ff);
      end
      pos_next = (CMP_W + 1)'(cnt_ff) + 1'b1;
      last     = pos_next >= {1'b0, dims_eff};
   end

   always_comb begin
      sum_w     = (WS_W + 1)'(ws_ff) + (WS_W + 1)'(alpha);
      fires_cur = fires_ff;
      tail_cur  = tail_ff;
      split_cur = split_ff;
      ws_cur    = ws_ff;
      item          = '0;
      item.op       = OP_DRAIN;
      if (func == FUNC_FRAME) begin
         // sample the frame decision on element 0
         if (cnt_ff == '0) begin
            if (sum_w >= (WS_W + 1)'(ONE_Q16)) begin
               fires_cur = 1'b1;
               split_cur = ONE_Q16 - SPLIT_W'(ws_ff);
               ws_cur    = WS_W'(sum_w - (WS_W + 1)'(ONE_Q16));
            end else begin
               fires_cur = 1'b0;
               split_cur = {1'b0, alpha};
               ws_cur    = WS_W'(sum_w);
            end
         end
         item.op   = fires_cur ? OP_FIRE : OP_ACC;
         item.emit = fires_cur;
      end else begin
         if (cnt_ff == '0) begin
            tail_cur = (ws_ff > WS_W'(thr_ff)) && (tok_ff != '0);
         end
         item.op   = OP_DRAIN;
         item.emit = tail_cur;
         item.tail = 1'b1;
      end
      item.elem_idx = ELEM_W'(cnt_ff);
      item.tok      = tok_ff;
      item.last     = last;
      item.split    = split_cur;
      item.ws       = SPLIT_W'(ws_cur);
      item.value    = enc_value;
   end

   assign addr = cnt_ff;

   always_comb begin
      dims_in  = dims_ff;
      thr_in   = thr_ff;
      ws_in    = ws_ff;
      cnt_in   = cnt_ff;
      fires_in = fires_ff;
      split_in = split_ff;
      tok_in   = tok_ff;
      tail_in  = tail_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_DIMS:     dims_in = csr_data[DIMS_W-1:0];
            REG_TAIL_THR: thr_in  = csr_data[THR_W-1:0];
            default:      ;
         endcase
      end
      if (accept) begin
         ws_in    = ws_cur;
         fires_in = fires_cur;
         split_in = split_cur;
         tail_in  = tail_cur;
         if (last) begin
            cnt_in = '0;
            if (func == FUNC_FRAME) begin
               if (fires_cur && (tok_ff != '1)) begin
                  tok_in = tok_ff + 1'b1;
               end
            end else begin
               // drain done: restart the utterance
               ws_in    = '0;
               split_in = '0;
               fires_in = 1'b0;
               tail_in  = 1'b0;
               tok_in   = '0;
            end
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= DIMS_RESET;
         thr_ff   <= THR_RESET;
         ws_ff    <= '0;
         cnt_ff   <= '0;
         fires_ff <= 1'b0;
         split_ff <= '0;
         tok_ff   <= '0;
         tail_ff  <= 1'b0;
      end else begin
         dims_ff  <= dims_in;
         thr_ff   <= thr_in;
         ws_ff    <= ws_in;
         cnt_ff   <= cnt_in;
         fires_ff <= fires_in;
         split_ff <= split_in;
         tok_ff   <= tok_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

@@ hdl/ifte_datapath.sv @@
module ifte_datapath #(
   parameter int MAX_DIMS = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ifte_pkg::item_type    in_item,
   input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] in_addr,
   output logic                  clearing,
   output logic [1:0]            inflight,
   output logic                  res_valid,
   output ifte_pkg::result_type  result
);
   import ifte_pkg::*;

   localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_DIMS - 1);

   logic signed [STORE_W-1:0] store_mem [MAX_DIMS];

   clr_state_type             st_ff, st_in;
   logic [IDX_W-1:0]          clr_ptr_ff, clr_ptr_in;

   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic signed [STORE_W-1:0] wr_data;
   logic signed [STORE_W-1:0] rdata_ff;

   logic                      s1_v_ff;
   item_type                  s1_item_ff;
   logic [IDX_W-1:0]          s1_addr_ff;

   logic                      s2_v_ff;
   item_type                  s2_item_ff;
   logic [IDX_W-1:0]          s2_addr_ff;
   logic signed [STORE_W-1:0] s2_base_ff;
   logic signed [PROD_W-1:0]  s2_psplit_ff;
   logic signed [PROD_W-1:0]  s2_pws_ff;

   logic signed [SPLIT_W:0]   s1_split;
   logic signed [SPLIT_W:0]   s1_ws;
   logic signed [PROD_W-1:0]  s1_psplit;
   logic signed [PROD_W-1:0]  s1_pws;
   logic signed [STORE_W-1:0] s1_base;

   logic signed [ACC_W-1:0]   s2_acc;
   logic signed [STORE_W-1:0] s2_wdata;
   logic signed [STORE_W-1:0] s2_out;

   // zero the store once after reset
   always_comb begin
      st_in      = st_ff;
      clr_ptr_in = clr_ptr_ff;
      case (st_ff)
         ST_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == LAST_ADDR) begin
               st_in = ST_RUN;
            end
         end
         ST_RUN:  ;
         default: st_in = ST_CLEAR;
      endcase
   end

   assign clearing = (st_ff != ST_RUN);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_CLEAR;
         clr_ptr_ff <= '0;
      end else begin
         st_ff      <= st_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   assign wr_en   = clearing || s2_v_ff;
   assign wr_addr = clearing ? clr_ptr_ff : s2_addr_ff;
   assign wr_data = clearing ? '0 : s2_wdata;

   // bypass a write that lands in the same cycle as the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (in_valid) begin
         rdata_ff <= (wr_en && (wr_addr == in_addr)) ? wr_data : store_mem[in_addr];
      end
   end

   always_comb begin
      s1_split  = {1'b0, s1_item_ff.split};
      s1_ws     = {1'b0, s1_item_ff.ws};
      s1_psplit = s1_split * s1_item_ff.value;
      s1_pws    = s1_ws * s1_item_ff.value;
      // forward the entry the item ahead is about to write
      s1_base   = (s2_v_ff && (s2_addr_ff == s1_addr_ff)) ? s2_wdata : rdata_ff;
   end

   always_comb begin
      s2_acc = {s2_base_ff[STORE_W-1], s2_base_ff[STORE_W-1], s2_base_ff[STORE_W-1], s2_base_ff}
             + {s2_psplit_ff[PROD_W-1], s2_psplit_ff};
      case (s2_item_ff.op)
         OP_ACC: begin
            s2_wdata = sat32(s2_acc);
            s2_out   = s2_wdata;
         end
         OP_FIRE: begin
            s2_wdata = sat32({s2_pws_ff[PROD_W-1], s2_pws_ff});
            s2_out   = sat32(s2_acc);
         end
         OP_DRAIN: begin
            s2_wdata = '0;
            s2_out   = s2_base_ff;
         end
         default: begin
            s2_wdata = '0;
            s2_out   = s2_base_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff   <= in_item;
      s1_addr_ff   <= in_addr;
      s2_item_ff   <= s1_item_ff;
      s2_addr_ff   <= s1_addr_ff;
      s2_base_ff   <= s1_base;
      s2_psplit_ff <= s1_psplit;
      s2_pws_ff    <= s1_pws;
   end

   assign inflight = {1'b0, s1_v_ff} + {1'b0, s2_v_ff};

   assign res_valid       = s2_v_ff && s2_item_ff.emit;
   assign result.embed    = s2_out;
   assign result.elem_idx = s2_item_ff.elem_idx;
   assign result.tok      = s2_item_ff.tok;
   assign result.last     = s2_item_ff.last;
   assign result.tail     = s2_item_ff.tail;

endmodule

@@ hdl/ifte_out_fifo.sv @@
module ifte_out_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  ifte_pkg::result_type               push_data,
   input  logic                               pop_ready,
   output logic                               pop_valid,
   output ifte_pkg::result_type               pop_data,
   output logic [ifte_pkg::FIFO_CNT_W-1:0]    count
);
   import ifte_pkg::*;

   result_type               fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                     pop;

   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = fifo_mem[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;
   assign count     = cnt_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ hdl/integrate_and_fire_token_emitter_top.sv @@
// Integrate-and-fire token emitter.
// req channel: one encoder element per transfer. req_tuser is the item kind
// (0 frame element, 1 end-of-utterance drain element); req_tdata carries
// alpha (Q0.16) and the encoder value (Q8.8). Frames are dims_in_use items.
// rsp channel: one embedding element (Q8.24) per transfer for firing frames
// and tail drains; rsp_tlast marks the final element, rsp_tuser a tail token.
// csr channel: register 0 dims_in_use, register 1 tail_threshold; always ready.
// Throughput is one item per clock while req_tready is high. A req transfer
// reaches rsp_tvalid through store read, multiply, add/saturate with write
// back, then the output queue. The embedding store is a single-port-write,
// single-port-read memory with forwarding, so neighboring elements of the same
// entry chain without stalls.
// After reset every store entry is zeroed with req_tready low.
// A 4-entry output queue absorbs rsp stalls; req_tready drops once queued and
// in-flight items fill it, and rises again as rsp transfers drain it.
module integrate_and_fire_token_emitter_top #(
   parameter int MAX_DIMS = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // alpha, enc_value
   input  logic                               req_tuser,  // func
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,  // embed_value, element_index,
                                                          // token_index, zero fill
   output logic                               rsp_tlast,  // last_element
   output logic                               rsp_tuser,  // is_tail
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ifte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ifte_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ifte_pkg::*;

   localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   logic                    accept;
   logic                    clearing;
   logic [1:0]              inflight;
   logic [IDX_W-1:0]        addr;
   item_type                item;
   logic                    res_valid;
   result_type              result;
   result_type              head;
   logic [FIFO_CNT_W-1:0]   fifo_cnt;
   logic [FIFO_CNT_W:0]     occupancy;

   assign csr_ready  = 1'b1;
   assign occupancy  = (FIFO_CNT_W + 1)'(fifo_cnt) + (FIFO_CNT_W + 1)'(inflight);
   assign req_tready = !clearing && (occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   ifte_ctrl #(
      .MAX_DIMS (MAX_DIMS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .func      (req_tuser),
      .alpha     (req_tdata[15:0]),
      .enc_value (req_tdata[31:16]),
      .addr      (addr),
      .item      (item)
   );

   ifte_datapath #(
      .MAX_DIMS (MAX_DIMS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (item),
      .in_addr   (addr),
      .clearing  (clearing),
      .inflight  (inflight),
      .res_valid (res_valid),
      .result    (result)
   );

   ifte_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (result),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_data  (head),
      .count     (fifo_cnt)
   );

   assign rsp_tdata = {7'd0, head.tok, head.elem_idx, head.embed};
   assign rsp_tlast = head.last;
   assign rsp_tuser = head.tail;

endmodule

@@ hdl/ifte_checker.sv @@
module ifte_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // the store is being cleared right after reset
   a_no_accept_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[63:57] == 7'd0))
      else $error("rsp_tdata fill bits not zero");

endmodule

bind integrate_and_fire_token_emitter_top ifte_checker u_ifte_checker (.*);
